// ===== rtl/fjtok_pkg.sv =====
// Shared types, codes and character helpers for the flat JSON line tokenizer.
`default_nettype none
package fjtok_pkg;

   localparam int MaxResults = 5;

   typedef enum logic [4:0] {
      PH_START   = 5'd0,
      PH_SKIP    = 5'd1,
      PH_SKIPC   = 5'd2,
      PH_OPEN    = 5'd3,
      PH_KEYX    = 5'd4,
      PH_COLON   = 5'd5,
      PH_VALX    = 5'd6,
      PH_NUM     = 5'd7,
      PH_LIT     = 5'd8,
      PH_AFTER   = 5'd9,
      PH_CLOSED  = 5'd10,
      PH_CLOSEDC = 5'd11,
      PH_K_CHR   = 5'd12,
      PH_K_ESC   = 5'd13,
      PH_K_HEX   = 5'd14,
      PH_K_BSL   = 5'd15,
      PH_K_U     = 5'd16,
      PH_K_LOHEX = 5'd17,
      PH_V_CHR   = 5'd18,
      PH_V_ESC   = 5'd19,
      PH_V_HEX   = 5'd20,
      PH_V_BSL   = 5'd21,
      PH_V_U     = 5'd22,
      PH_V_LOHEX = 5'd23
   } phase_type;

   typedef enum logic [1:0] {
      KIND_KEY     = 2'd0,
      KIND_VALUE   = 2'd1,
      KIND_PAIR    = 2'd2,
      KIND_VERDICT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      VERD_OBJECT    = 2'd0,
      VERD_SKIP      = 2'd1,
      VERD_MALFORMED = 2'd2,
      VERD_SPARE     = 2'd3
   } verdict_type;

   // Literal selector
   localparam logic [1:0] LitTrue  = 2'd0;
   localparam logic [1:0] LitFalse = 2'd1;
   localparam logic [1:0] LitNull  = 2'd2;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    token_kind;
      verdict_type line_verdict;
   } result_type;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      hex_value = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b - 8'h30;
         hex_value = {1'b1, d[3:0]};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = b - 8'h57;
         hex_value = {1'b1, d[3:0]};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = b - 8'h37;
         hex_value = {1'b1, d[3:0]};
      end
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] c, input logic [2:0] p);
      lit_char = 8'h00;
      case (c)
         LitTrue: begin
            case (p)
               3'd0: lit_char = "t";
               3'd1: lit_char = "r";
               3'd2: lit_char = "u";
               3'd3: lit_char = "e";
               default: lit_char = 8'h00;
            endcase
         end
         LitFalse: begin
            case (p)
               3'd0: lit_char = "f";
               3'd1: lit_char = "a";
               3'd2: lit_char = "l";
               3'd3: lit_char = "s";
               3'd4: lit_char = "e";
               default: lit_char = 8'h00;
            endcase
         end
         LitNull: begin
            case (p)
               3'd0: lit_char = "n";
               3'd1: lit_char = "u";
               3'd2: lit_char = "l";
               3'd3: lit_char = "l";
               default: lit_char = 8'h00;
            endcase
         end
         default: lit_char = 8'h00;
      endcase
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] c);
      lit_len = (c == LitFalse) ? 3'd5 : 3'd4;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fjtok_req_if.sv =====
// Input channel: one text byte or end-of-line marker per transfer.
`default_nettype none
interface fjtok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       line_end;

   modport source (output valid, output line_byte, output line_end, input ready);
   modport sink (input valid, input line_byte, input line_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/fjtok_rsp_if.sv =====
// Result channel: one decoded byte, pair mark or line verdict per transfer.
`default_nettype none
interface fjtok_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] token_kind;
   logic [1:0] line_verdict;
   logic       last;

   modport source (output valid, output out_byte, output token_kind, output line_verdict,
                   output last, input ready);
   modport sink (input valid, input out_byte, input token_kind, input line_verdict,
                 input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/flat_json_object_line_tokenizer.sv =====
// Top level of the flat JSON object line tokenizer.
`default_nettype none
// Tokenizes one line of a line-per-record JSON array per run of transfers: feed
// the line's bytes, then one transfer with line_end set. Each input transfer
// is decoded in the cycle it is taken and its results (0 to 4: key/value bytes,
// pair-complete marks, and the line verdict on line_end) land in a 5-entry
// result register that drains one result per cycle while the consumer is ready;
// last flags the final result of an input. Input is taken in every cycle in
// which that register empties: plain ASCII runs at one byte per cycle unless
// the output stalls, and an input with several results holds off the next
// until all drain (up to 4 UTF-8 bytes for a \u surrogate pair). On a
// malformed verdict the consumer drops any bytes already delivered for that line.
module flat_json_object_line_tokenizer (
   input  wire         clock,
   input  wire         reset,
   fjtok_req_if.sink   req_chan,
   fjtok_rsp_if.source rsp_chan
);
   import fjtok_pkg::*;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [15:0] cu_ff, cu_in;
   logic [9:0]  hs_ff, hs_in;
   logic [2:0]  hexn_ff, hexn_in;
   logic [2:0]  lpos_ff, lpos_in;
   logic [1:0]  lch_ff, lch_in;
   logic [2:0]  nph_ff, nph_in;
   logic        failed_ff, failed_in;

   // Result buffer
   result_type  buf_ff [MaxResults];
   logic [2:0]  cnt_ff, idx_ff;

   result_type  res [MaxResults];
   logic [2:0]  res_n;

   logic        accept, pop, at_last;

   assign at_last = (idx_ff == cnt_ff - 3'd1);
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == 3'd0) || (pop && at_last);
   assign accept  = req_chan.valid && req_chan.ready;

   // Decode one input against the current state
   always_comb begin
      logic [7:0]  b;
      logic        is_val;
      kind_type    kd;
      logic [4:0]  hx;
      logic [15:0] cu;
      logic [2:0]  hn;
      logic        do_utf;
      logic [20:0] cp;
      logic        term;
      logic        bad;
      logic [2:0]  np;
      verdict_type vd;
      logic [10:0] hsx;

      b = req_chan.line_byte;
      is_val = (phase_ff >= PH_V_CHR);
      kd = is_val ? KIND_VALUE : KIND_KEY;
      hx = hex_value(b);
      cu = {cu_ff[11:0], hx[3:0]};
      hn = hexn_ff + 3'd1;
      do_utf = 1'b0;
      cp = 21'd0;
      term = 1'b0;
      bad = 1'b0;
      np = nph_ff;
      vd = VERD_MALFORMED;
      hsx = 11'd0;
      phase_in = phase_ff;
      cu_in = cu_ff;
      hs_in = hs_ff;
      hexn_in = hexn_ff;
      lpos_in = lpos_ff;
      lch_in = lch_ff;
      nph_in = nph_ff;
      failed_in = failed_ff;
      res_n = 3'd0;
      for (int i = 0; i < MaxResults; i++) begin
         res[i] = '{8'h00, KIND_KEY, VERD_OBJECT};
      end

      if (req_chan.line_end) begin
         if (!failed_ff) begin
            if (phase_ff == PH_START || phase_ff == PH_SKIP || phase_ff == PH_SKIPC) begin
               vd = VERD_SKIP;
            end else if (phase_ff == PH_CLOSED || phase_ff == PH_CLOSEDC) begin
               vd = VERD_OBJECT;
            end
         end
         phase_in = PH_START;
         cu_in = 16'd0;
         hs_in = 10'd0;
         hexn_in = 3'd0;
         lpos_in = 3'd0;
         lch_in = 2'd0;
         nph_in = 3'd0;
         failed_in = 1'b0;
         res[0] = '{8'h00, KIND_VERDICT, vd};
         res_n = 3'd1;
      end else if (!failed_ff) begin
         unique case (phase_ff) inside
            PH_START: begin
               if (!is_ws(b)) begin
                  if (b == "[" || b == "]") phase_in = PH_SKIP;
                  else if (b == ",") phase_in = PH_SKIPC;
                  else if (b == "{") phase_in = PH_OPEN;
                  else failed_in = 1'b1;
               end
            end
            PH_SKIP: begin
               if (!is_ws(b)) begin
                  if (b == ",") phase_in = PH_SKIPC;
                  else failed_in = 1'b1;
               end
            end
            PH_SKIPC, PH_CLOSEDC: begin
               if (!is_ws(b)) failed_in = 1'b1;
            end
            PH_OPEN: begin
               if (!is_ws(b)) begin
                  if (b == "\"") phase_in = PH_K_CHR;
                  else if (b == "}") phase_in = PH_CLOSED;
                  else failed_in = 1'b1;
               end
            end
            PH_KEYX: begin
               if (!is_ws(b)) begin
                  if (b == "\"") phase_in = PH_K_CHR;
                  else failed_in = 1'b1;
               end
            end
            PH_COLON: begin
               if (!is_ws(b)) begin
                  if (b == ":") phase_in = PH_VALX;
                  else failed_in = 1'b1;
               end
            end
            PH_VALX: begin
               if (!is_ws(b)) begin
                  if (b == "\"") begin
                     phase_in = PH_V_CHR;
                  end else if (b == "-" || is_digit(b)) begin
                     res[0] = '{b, KIND_VALUE, VERD_OBJECT};
                     res_n = 3'd1;
                     nph_in = (b == "-") ? 3'd0 : ((b == "0") ? 3'd1 : 3'd2);
                     phase_in = PH_NUM;
                  end else if (b == "t" || b == "f" || b == "n") begin
                     lch_in = (b == "t") ? LitTrue : ((b == "f") ? LitFalse : LitNull);
                     lpos_in = 3'd1;
                     if (b != "n") begin
                        res[0] = '{(b == "t") ? 8'h54 : 8'h46, KIND_VALUE, VERD_OBJECT};
                        res_n = 3'd1;
                     end
                     phase_in = PH_LIT;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
            end
            PH_NUM: begin
               case (nph_ff) inside
                  3'd0: begin
                     if (b == "0") np = 3'd1;
                     else if (is_digit(b)) np = 3'd2;
                     else bad = 1'b1;
                  end
                  3'd1, 3'd2: begin
                     if (nph_ff == 3'd2 && is_digit(b)) np = 3'd2;
                     else if (b == ".") np = 3'd3;
                     else if (b == "e" || b == "E") np = 3'd5;
                     else term = 1'b1;
                  end
                  3'd3: begin
                     if (is_digit(b)) np = 3'd4;
                     else bad = 1'b1;
                  end
                  3'd4: begin
                     if (is_digit(b)) np = 3'd4;
                     else if (b == "e" || b == "E") np = 3'd5;
                     else term = 1'b1;
                  end
                  3'd5: begin
                     if (b == "+" || b == "-") np = 3'd6;
                     else if (is_digit(b)) np = 3'd7;
                     else bad = 1'b1;
                  end
                  3'd6: begin
                     if (is_digit(b)) np = 3'd7;
                     else bad = 1'b1;
                  end
                  default: begin
                     if (!is_digit(b)) term = 1'b1;
                  end
               endcase
               if (bad) begin
                  failed_in = 1'b1;
               end else if (!term) begin
                  nph_in = np;
                  res[0] = '{b, KIND_VALUE, VERD_OBJECT};
                  res_n = 3'd1;
               end else begin
                  // number ends here; the byte is then a separator
                  res[0] = '{8'h00, KIND_PAIR, VERD_OBJECT};
                  res_n = 3'd1;
                  phase_in = PH_AFTER;
                  if (!is_ws(b)) begin
                     if (b == ",") phase_in = PH_KEYX;
                     else if (b == "}") phase_in = PH_CLOSED;
                     else failed_in = 1'b1;
                  end
               end
            end
            PH_LIT: begin
               if (lch_ff > LitNull || lpos_ff >= lit_len(lch_ff)
                   || b != lit_char(lch_ff, lpos_ff)) begin
                  failed_in = 1'b1;
               end else begin
                  lpos_in = lpos_ff + 3'd1;
                  if (lch_ff != LitNull) begin
                     res[0] = '{b, KIND_VALUE, VERD_OBJECT};
                     res_n = 3'd1;
                  end
                  if (lpos_ff + 3'd1 == lit_len(lch_ff)) begin
                     res[res_n] = '{8'h00, KIND_PAIR, VERD_OBJECT};
                     res_n = res_n + 3'd1;
                     phase_in = PH_AFTER;
                  end
               end
            end
            PH_AFTER: begin
               if (!is_ws(b)) begin
                  if (b == ",") phase_in = PH_KEYX;
                  else if (b == "}") phase_in = PH_CLOSED;
                  else failed_in = 1'b1;
               end
            end
            PH_CLOSED: begin
               if (!is_ws(b)) begin
                  if (b == ",") phase_in = PH_CLOSEDC;
                  else failed_in = 1'b1;
               end
            end
            PH_K_CHR, PH_V_CHR: begin
               if (b == "\"") begin
                  if (is_val) begin
                     res[0] = '{8'h00, KIND_PAIR, VERD_OBJECT};
                     res_n = 3'd1;
                     phase_in = PH_AFTER;
                  end else begin
                     phase_in = PH_COLON;
                  end
               end else if (b < 8'h20) begin
                  failed_in = 1'b1;
               end else if (b == "\\") begin
                  phase_in = is_val ? PH_V_ESC : PH_K_ESC;
               end else begin
                  res[0] = '{b, kd, VERD_OBJECT};
                  res_n = 3'd1;
               end
            end
            PH_K_ESC, PH_V_ESC: begin
               phase_in = is_val ? PH_V_CHR : PH_K_CHR;
               res_n = 3'd1;
               case (b) inside
                  8'h22, 8'h5C, 8'h2F: res[0] = '{b, kd, VERD_OBJECT};
                  "b": res[0] = '{8'h08, kd, VERD_OBJECT};
                  "f": res[0] = '{8'h0C, kd, VERD_OBJECT};
                  "n": res[0] = '{8'h0A, kd, VERD_OBJECT};
                  "r": res[0] = '{8'h0D, kd, VERD_OBJECT};
                  "t": res[0] = '{8'h09, kd, VERD_OBJECT};
                  "u": begin
                     res_n = 3'd0;
                     cu_in = 16'd0;
                     hexn_in = 3'd0;
                     phase_in = is_val ? PH_V_HEX : PH_K_HEX;
                  end
                  default: begin
                     res_n = 3'd0;
                     failed_in = 1'b1;
                  end
               endcase
            end
            PH_K_HEX, PH_V_HEX: begin
               if (!hx[4]) begin
                  failed_in = 1'b1;
               end else begin
                  cu_in = cu;
                  hexn_in = hn;
                  if (hn >= 3'd4) begin
                     if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
                        hs_in = cu[9:0];
                        phase_in = is_val ? PH_V_BSL : PH_K_BSL;
                     end else if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
                        failed_in = 1'b1;
                     end else begin
                        do_utf = 1'b1;
                        cp = {5'd0, cu};
                        phase_in = is_val ? PH_V_CHR : PH_K_CHR;
                     end
                  end
               end
            end
            PH_K_BSL, PH_V_BSL: begin
               if (b == "\\") phase_in = is_val ? PH_V_U : PH_K_U;
               else failed_in = 1'b1;
            end
            PH_K_U, PH_V_U: begin
               if (b == "u") begin
                  cu_in = 16'd0;
                  hexn_in = 3'd0;
                  phase_in = is_val ? PH_V_LOHEX : PH_K_LOHEX;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_K_LOHEX, PH_V_LOHEX: begin
               if (!hx[4]) begin
                  failed_in = 1'b1;
               end else begin
                  cu_in = cu;
                  hexn_in = hn;
                  if (hn >= 3'd4) begin
                     if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
                        hsx = {1'b0, hs_ff} + 11'h040;
                        do_utf = 1'b1;
                        cp = {hsx, cu[9:0]};
                        phase_in = is_val ? PH_V_CHR : PH_K_CHR;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
               end
            end
            default: failed_in = 1'b1;
         endcase
      end

      // UTF-8 encoding of a decoded code point
      if (do_utf) begin
         if (cp <= 21'h7F) begin
            res[0] = '{cp[7:0], kd, VERD_OBJECT};
            res_n = 3'd1;
         end else if (cp <= 21'h7FF) begin
            res[0] = '{{3'b110, cp[10:6]}, kd, VERD_OBJECT};
            res[1] = '{{2'b10, cp[5:0]}, kd, VERD_OBJECT};
            res_n = 3'd2;
         end else if (cp <= 21'hFFFF) begin
            res[0] = '{{4'b1110, cp[15:12]}, kd, VERD_OBJECT};
            res[1] = '{{2'b10, cp[11:6]}, kd, VERD_OBJECT};
            res[2] = '{{2'b10, cp[5:0]}, kd, VERD_OBJECT};
            res_n = 3'd3;
         end else begin
            res[0] = '{{5'b11110, cp[20:18]}, kd, VERD_OBJECT};
            res[1] = '{{2'b10, cp[17:12]}, kd, VERD_OBJECT};
            res[2] = '{{2'b10, cp[11:6]}, kd, VERD_OBJECT};
            res[3] = '{{2'b10, cp[5:0]}, kd, VERD_OBJECT};
            res_n = 3'd4;
         end
      end
   end

   // Parse state update on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         cu_ff <= 16'd0;
         hs_ff <= 10'd0;
         hexn_ff <= 3'd0;
         lpos_ff <= 3'd0;
         lch_ff <= 2'd0;
         nph_ff <= 3'd0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cu_ff <= cu_in;
         hs_ff <= hs_in;
         hexn_ff <= hexn_in;
         lpos_ff <= lpos_in;
         lch_ff <= lch_in;
         nph_ff <= nph_in;
         failed_ff <= failed_in;
      end
   end

   // Result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 3'd0;
      end else if (accept) begin
         cnt_ff <= res_n;
         idx_ff <= 3'd0;
      end else if (pop) begin
         if (at_last) cnt_ff <= 3'd0;
         idx_ff <= idx_ff + 3'd1;
      end
   end

   // Result buffer payload
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MaxResults; i++) begin
            buf_ff[i] <= res[i];
         end
      end
   end

   assign rsp_chan.valid        = (cnt_ff != 3'd0);
   assign rsp_chan.out_byte     = buf_ff[idx_ff].out_byte;
   assign rsp_chan.token_kind   = buf_ff[idx_ff].token_kind;
   assign rsp_chan.line_verdict = buf_ff[idx_ff].line_verdict;
   assign rsp_chan.last         = at_last;

   // Checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (idx_ff < cnt_ff) && (cnt_ff <= 3'd5))
      else $error("result index past fill count");

   a_eol_verdict: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.line_end |=> rsp_chan.valid && rsp_chan.last
         && (rsp_chan.token_kind == KIND_VERDICT))
      else $error("end of line did not give a single verdict");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.line_end |=> (phase_ff == PH_START) && !failed_ff)
      else $error("parse state not cleared at end of line");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      pop && at_last && !accept |=> !rsp_chan.valid)
      else $error("result buffer not empty after final transfer");

   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && failed_ff && !req_chan.line_end |=> !rsp_chan.valid)
      else $error("results after a line error");

endmodule
`default_nettype wire

// ===== sim/tb_fjtok_pkg.sv =====
// Testbench-side predictor and result store for the flat JSON line tokenizer.
`timescale 1ns / 1ps
package tb_fjtok_pkg;
   import fjtok_pkg::*;

   class tokenizer_scoreboard;
      phase_type   phase;
      logic [15:0] unit_acc;
      logic [9:0]  hi_sur;
      logic [2:0]  hex_count;
      logic [2:0]  lit_pos;
      logic [1:0]  lit_sel;
      logic [2:0]  num_state;
      logic        failed;
      result_type  pending[$];
      bit          pending_last[$];
      result_type  step_buf[$];
      int          errors;

      function new();
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         phase = PH_START;
         unit_acc = '0;
         hi_sur = '0;
         hex_count = '0;
         lit_pos = '0;
         lit_sel = '0;
         num_state = '0;
         failed = 1'b0;
      endfunction

      function void put(logic [7:0] b, kind_type k, verdict_type v);
         result_type r;
         r.out_byte = b;
         r.token_kind = k;
         r.line_verdict = v;
         step_buf = {step_buf, r};
      endfunction

      function void put_utf8(logic [20:0] cp, kind_type k);
         if (cp <= 21'h7F) begin
            put(cp[7:0], k, VERD_OBJECT);
         end else if (cp <= 21'h7FF) begin
            put(8'hC0 | cp[10:6], k, VERD_OBJECT);
            put(8'h80 | cp[5:0], k, VERD_OBJECT);
         end else if (cp <= 21'hFFFF) begin
            put(8'hE0 | cp[15:12], k, VERD_OBJECT);
            put(8'h80 | cp[11:6], k, VERD_OBJECT);
            put(8'h80 | cp[5:0], k, VERD_OBJECT);
         end else begin
            put(8'hF0 | cp[20:18], k, VERD_OBJECT);
            put(8'h80 | cp[17:12], k, VERD_OBJECT);
            put(8'h80 | cp[11:6], k, VERD_OBJECT);
            put(8'h80 | cp[5:0], k, VERD_OBJECT);
         end
      endfunction

      function bit ws(logic [7:0] b);
         return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
      endfunction

      function bit dig(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      // returns 0 and flags the line on a non-hex digit
      function bit take_hex(logic [7:0] b);
         logic [7:0] d;
         if (dig(b)) d = b - 8'h30;
         else if (b >= "a" && b <= "f") d = b - 8'h57;
         else if (b >= "A" && b <= "F") d = b - 8'h37;
         else begin
            failed = 1'b1;
            return 0;
         end
         unit_acc = {unit_acc[11:0], d[3:0]};
         hex_count = hex_count + 3'd1;
         return 1;
      endfunction

      function void after_value(logic [7:0] b);
         if (ws(b)) return;
         if (b == ",") phase = PH_KEYX;
         else if (b == "}") phase = PH_CLOSED;
         else failed = 1'b1;
      endfunction

      function void string_char(bit is_val, logic [7:0] b);
         kind_type k;
         int sub;
         int base;
         base = is_val ? PH_V_CHR : PH_K_CHR;
         k = is_val ? KIND_VALUE : KIND_KEY;
         sub = int'(phase) - base;
         case (sub)
            0: begin
               if (b == "\"") begin
                  if (is_val) begin
                     put(8'h00, KIND_PAIR, VERD_OBJECT);
                     phase = PH_AFTER;
                  end else phase = PH_COLON;
               end else if (b < 8'h20) failed = 1'b1;
               else if (b == "\\") phase = phase_type'(base + 1);
               else put(b, k, VERD_OBJECT);
            end
            1: begin
               phase = phase_type'(base);
               case (b) inside
                  "\"", "\\", "/": put(b, k, VERD_OBJECT);
                  "b": put(8'h08, k, VERD_OBJECT);
                  "f": put(8'h0C, k, VERD_OBJECT);
                  "n": put(8'h0A, k, VERD_OBJECT);
                  "r": put(8'h0D, k, VERD_OBJECT);
                  "t": put(8'h09, k, VERD_OBJECT);
                  "u": begin
                     unit_acc = '0;
                     hex_count = '0;
                     phase = phase_type'(base + 2);
                  end
                  default: failed = 1'b1;
               endcase
            end
            2: begin
               if (take_hex(b) && hex_count >= 3'd4) begin
                  if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
                     hi_sur = 10'(unit_acc - 16'hD800);
                     phase = phase_type'(base + 3);
                  end else if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
                     failed = 1'b1;
                  end else begin
                     put_utf8({5'd0, unit_acc}, k);
                     phase = phase_type'(base);
                  end
               end
            end
            3: if (b == "\\") phase = phase_type'(base + 4); else failed = 1'b1;
            4: begin
               if (b == "u") begin
                  unit_acc = '0;
                  hex_count = '0;
                  phase = phase_type'(base + 5);
               end else failed = 1'b1;
            end
            default: begin
               if (take_hex(b) && hex_count >= 3'd4) begin
                  if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
                     put_utf8(21'h10000 + {1'b0, hi_sur, 10'd0} + (unit_acc - 16'hDC00), k);
                     phase = phase_type'(base);
                  end else failed = 1'b1;
               end
            end
         endcase
      endfunction

      function void number_char(logic [7:0] b);
         bit cont;
         bit bad;
         logic [2:0] nxt;
         cont = 0;
         bad = 0;
         nxt = num_state;
         case (num_state) inside
            3'd0: if (b == "0") begin nxt = 3'd1; cont = 1; end
               else if (dig(b)) begin nxt = 3'd2; cont = 1; end
               else bad = 1;
            3'd1, 3'd2: if (num_state == 3'd2 && dig(b)) cont = 1;
               else if (b == ".") begin nxt = 3'd3; cont = 1; end
               else if (b == "e" || b == "E") begin nxt = 3'd5; cont = 1; end
            3'd3: if (dig(b)) begin nxt = 3'd4; cont = 1; end else bad = 1;
            3'd4: if (dig(b)) cont = 1;
               else if (b == "e" || b == "E") begin nxt = 3'd5; cont = 1; end
            3'd5: if (b == "+" || b == "-") begin nxt = 3'd6; cont = 1; end
               else if (dig(b)) begin nxt = 3'd7; cont = 1; end
               else bad = 1;
            3'd6: if (dig(b)) begin nxt = 3'd7; cont = 1; end else bad = 1;
            default: if (dig(b)) cont = 1;
         endcase
         if (bad) begin
            failed = 1'b1;
         end else if (cont) begin
            num_state = nxt;
            put(b, KIND_VALUE, VERD_OBJECT);
         end else begin
            put(8'h00, KIND_PAIR, VERD_OBJECT);
            phase = PH_AFTER;
            after_value(b);
         end
      endfunction

      function logic [7:0] lit_letter(logic [1:0] c, logic [2:0] p);
         string s;
         s = (c == LitTrue) ? "true" : (c == LitFalse) ? "false" : "null";
         return (p < s.len()) ? s[p] : 8'h00;
      endfunction

      function void literal_char(logic [7:0] b);
         int n;
         n = (lit_sel == LitFalse) ? 5 : 4;
         if (lit_sel > LitNull || lit_pos >= n || b != lit_letter(lit_sel, lit_pos)) begin
            failed = 1'b1;
            return;
         end
         if (lit_sel != LitNull) put(b, KIND_VALUE, VERD_OBJECT);
         lit_pos = lit_pos + 3'd1;
         if (lit_pos == n) begin
            put(8'h00, KIND_PAIR, VERD_OBJECT);
            phase = PH_AFTER;
         end
      endfunction

      function void value_start(logic [7:0] b);
         if (ws(b)) return;
         if (b == "\"") phase = PH_V_CHR;
         else if (b == "-" || dig(b)) begin
            put(b, KIND_VALUE, VERD_OBJECT);
            num_state = (b == "-") ? 3'd0 : (b == "0") ? 3'd1 : 3'd2;
            phase = PH_NUM;
         end else if (b == "t" || b == "f" || b == "n") begin
            lit_sel = (b == "t") ? LitTrue : (b == "f") ? LitFalse : LitNull;
            lit_pos = 3'd1;
            if (b == "t") put("T", KIND_VALUE, VERD_OBJECT);
            if (b == "f") put("F", KIND_VALUE, VERD_OBJECT);
            phase = PH_LIT;
         end else failed = 1'b1;
      endfunction

      function void text_char(logic [7:0] b);
         if (phase >= PH_V_CHR) begin
            string_char(1, b);
            return;
         end
         if (phase >= PH_K_CHR) begin
            string_char(0, b);
            return;
         end
         case (phase) inside
            PH_START: if (!ws(b)) begin
               if (b == "[" || b == "]") phase = PH_SKIP;
               else if (b == ",") phase = PH_SKIPC;
               else if (b == "{") phase = PH_OPEN;
               else failed = 1'b1;
            end
            PH_SKIP: if (!ws(b)) begin
               if (b == ",") phase = PH_SKIPC; else failed = 1'b1;
            end
            PH_SKIPC, PH_CLOSEDC: if (!ws(b)) failed = 1'b1;
            PH_OPEN: if (!ws(b)) begin
               if (b == "\"") phase = PH_K_CHR;
               else if (b == "}") phase = PH_CLOSED;
               else failed = 1'b1;
            end
            PH_KEYX: if (!ws(b)) begin
               if (b == "\"") phase = PH_K_CHR; else failed = 1'b1;
            end
            PH_COLON: if (!ws(b)) begin
               if (b == ":") phase = PH_VALX; else failed = 1'b1;
            end
            PH_VALX: value_start(b);
            PH_NUM: number_char(b);
            PH_LIT: literal_char(b);
            PH_AFTER: after_value(b);
            PH_CLOSED: if (!ws(b)) begin
               if (b == ",") phase = PH_CLOSEDC; else failed = 1'b1;
            end
            default: failed = 1'b1;
         endcase
      endfunction

      // predict the results of one accepted input transfer
      function void note_input(logic [7:0] b, logic eol);
         verdict_type v;
         step_buf.delete();
         if (eol) begin
            v = VERD_MALFORMED;
            if (!failed) begin
               if (phase inside {PH_START, PH_SKIP, PH_SKIPC}) v = VERD_SKIP;
               else if (phase inside {PH_CLOSED, PH_CLOSEDC}) v = VERD_OBJECT;
            end
            clear_line();
            put(8'h00, KIND_VERDICT, v);
         end else if (!failed) begin
            text_char(b);
         end
         foreach (step_buf[i]) begin
            pending = {pending, step_buf[i]};
            pending_last = {pending_last, bit'(i == step_buf.size() - 1)};
         end
      endfunction

      function void check_result(logic [7:0] b, logic [1:0] k, logic [1:0] v, logic lst);
         result_type e;
         bit el;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result byte=%h kind=%0d verdict=%0d last=%0d",
                     $time, b, k, v, lst);
            errors++;
            return;
         end
         e = pending.pop_front();
         el = pending_last.pop_front();
         if (e.out_byte !== b || e.token_kind !== k || e.line_verdict !== v || el !== lst) begin
            $display("%0t: mismatch expected byte=%h kind=%0d verdict=%0d last=%0d",
                     $time, e.out_byte, e.token_kind, e.line_verdict, el);
            $display("%0t:          actual   byte=%h kind=%0d verdict=%0d last=%0d",
                     $time, b, k, v, lst);
            errors++;
         end
      endfunction
   endclass
endpackage

// ===== sim/tb_flat_json_object_line_tokenizer.sv =====
// Top-level testbench for the flat JSON object line tokenizer.
`timescale 1ns / 1ps
module tb_flat_json_object_line_tokenizer;
   import fjtok_pkg::*;
   import tb_fjtok_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   fjtok_req_if req_chan ();
   fjtok_rsp_if rsp_chan ();
   tokenizer_scoreboard board;
   bit hold_off = 0;
   bit stim_done = 0;
   int sent_count = 0;

   flat_json_object_line_tokenizer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #2 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.line_byte = 8'h00;
      req_chan.line_end = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   // note accepted inputs, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_input(req_chan.line_byte, req_chan.line_end);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result(rsp_chan.out_byte, rsp_chan.token_kind,
                               rsp_chan.line_verdict, rsp_chan.last);
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) rsp_chan.ready <= 1'b0;
      else if (($time / 400) % 3 == 0) rsp_chan.ready <= 1'b1;
      else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      @(posedge clock);
      wait (sent_count > 150);
      hold_off <= 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   int gap_left = 0;
   int burst_left = 8;

   // offer one byte or line end; wait for its transfer
   task automatic send_item(input logic [7:0] b, input logic eol);
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      req_chan.valid <= 1'b1;
      req_chan.line_byte <= b;
      req_chan.line_end <= eol;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_left > 0) req_chan.valid <= 1'b0;
      end
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(s[i], 1'b0);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_item(8'($urandom), 1'b1);
   endtask

   function automatic string rand_string_body();
      string s;
      int n;
      s = "";
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: s = {s, "\\n"};
            1: s = {s, "\\u00e9"};
            2: s = {s, "\\u20AC"};
            3: s = {s, "\\uD83D\\uDE00"};
            4: s = {s, string'(8'($urandom_range(8'h80, 8'hFF)))};
            5: s = {s, "\\\""};
            default: s = {s, string'(8'($urandom_range(8'h20, 8'h7E)))};
         endcase
         if (s[s.len() - 1] == "\\" && (s.len() < 2 || s[s.len() - 2] != "\\"))
            s = {s, "\\"};
      end
      return s;
   endfunction

   function automatic string rand_value();
      case ($urandom_range(0, 7))
         0: return "true";
         1: return "false";
         2: return "null";
         3: return $sformatf("%0d", $urandom_range(0, 99999));
         4: return $sformatf("-%0d.%0de+%0d", $urandom_range(0, 9), $urandom_range(0, 99),
                             $urandom_range(0, 9));
         5: return "0E-3";
         default: return {"\"", rand_string_body(), "\""};
      endcase
   endfunction

   function automatic string rand_object();
      string s;
      int n;
      n = $urandom_range(0, 3);
      s = ($urandom_range(0, 1) != 0) ? " {" : "{";
      for (int i = 0; i < n; i++) begin
         if (i > 0) s = {s, ", "};
         s = {s, "\"", rand_string_body(), "\":", rand_value()};
      end
      s = {s, "}"};
      if ($urandom_range(0, 1) != 0) s = {s, ","};
      return s;
   endfunction

   initial begin
      string s;
      int p;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_line("");
      send_line(" [ ");
      send_line("],");
      send_line(",");
      send_line("{}");
      send_line("{\"k\":\"\\u00FF\\uffff\\uDBFF\\uDFFF\\ud800\\udc00\\b\\f\\r\\t\\/\"},");
      send_line("{\"a\":tru}");
      send_line("{\"a\":-0.5E+12,\"b\":null}\t");
      send_line("{\"a\":\"\\uDC00\"}");
      send_line("{\"a\":\"\001\"}");
      send_line("{\"a\":01}");
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);

      // random lines: mostly well formed, some corrupted or truncated
      while (sent_count < 470) begin
         case ($urandom_range(0, 9))
            0: s = ($urandom_range(0, 1) != 0) ? "[" : " ], ";
            1, 2: begin
               s = rand_object();
               p = $urandom_range(0, s.len() - 1);
               if ($urandom_range(0, 1) != 0) s = s.substr(0, p);
               else s[p] = 8'($urandom);
            end
            default: s = rand_object();
         endcase
         send_line(s);
      end
      req_chan.valid <= 1'b0;
      stim_done = 1;
   end

   // wait for drain, then report
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/fjtok_pkg.sv
rtl/fjtok_req_if.sv
rtl/fjtok_rsp_if.sv
rtl/flat_json_object_line_tokenizer.sv
sim/tb_fjtok_pkg.sv
sim/tb_flat_json_object_line_tokenizer.sv
